// File: rtl/spwm_pkg.sv
// shared types, constants and sine table function for the sine pwm compare generator
package spwm_pkg;

    localparam int PHASE_BITS_DEF = 16;
    localparam int TABLE_BITS_DEF = 10;

    localparam int STEP_W     = 16;
    localparam int GAIN_W     = 15;
    localparam int OFFS_W     = 16;
    localparam int DIV_W      = 16;
    localparam int CNT_W      = 16;
    localparam int SINE_W     = 16;
    localparam int AMP_W      = 16;
    localparam int CMP_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 40;

    localparam logic [STEP_W-1:0] PHASE_STEP_RST    = 16'd393;
    localparam logic [GAIN_W-1:0] SINE_GAIN_RST     = 15'd6000;
    localparam logic [OFFS_W-1:0] MID_OFFSET_RST    = 16'd7500;
    localparam logic [DIV_W-1:0]  TOGGLE_DIVIDE_RST = 16'd10000;

    // fixed point constants of the table series (q28)
    localparam logic [63:0] Q28_ONE     = 64'd268435456;
    localparam logic [63:0] Q28_HALF_PI = 64'd421657428;
    localparam logic [63:0] SINE_FULL   = 64'd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_STEP    = 2'd0,
        CFG_SINE_GAIN     = 2'd1,
        CFG_MID_OFFSET    = 2'd2,
        CFG_TOGGLE_DIVIDE = 2'd3
    } t_cfg_idx;

    // control that travels alongside the data through the stages
    typedef struct packed {
        logic valid;
        logic neg;
        logic led;
    } t_stage;

    // round(32768 * sin(q / 2^qbits * pi/2)) by a q28 taylor series, folded at elaboration
    function automatic logic [15:0] quarter_sine(input int unsigned q, input int unsigned qbits);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        x    = (64'(q) * Q28_HALF_PI) >> qbits;
        term = x;
        sum  = x;
        for (int k = 1; k <= 6; k++) begin
            term = (term * x) >> 28;
            term = (term * x) >> 28;
            case (k)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                default: term = term / 64'd156;
            endcase
            if (k[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        r = (sum * SINE_FULL + (Q28_ONE >> 1)) >> 28;
        if (r > SINE_FULL) begin
            r = SINE_FULL;
        end
        return r[15:0];
    endfunction

endpackage

// File: rtl/spwm_sine_rom.sv
// quarter wave sine rom with registered read
module spwm_sine_rom #(
    parameter int QBITS = spwm_pkg::TABLE_BITS_DEF - 2
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [QBITS:0]              i_addr,
    output logic [spwm_pkg::SINE_W-1:0] o_data
);

    localparam int QSIZE = 1 << QBITS;

    logic [spwm_pkg::SINE_W-1:0] w_tab [QSIZE+1];
    logic [spwm_pkg::SINE_W-1:0] r_data;

    for (genvar g = 0; g <= QSIZE; g++) begin : g_tab
        assign w_tab[g] = spwm_pkg::quarter_sine(g, QBITS);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= w_tab[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

// File: rtl/spwm_phase_gen.sv
// phase accumulator, table address folding and tick divider
module spwm_phase_gen #(
    parameter int PHASE_BITS = spwm_pkg::PHASE_BITS_DEF,
    parameter int TABLE_BITS = spwm_pkg::TABLE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_take,
    input  logic [spwm_pkg::STEP_W-1:0]  i_phase_step,
    input  logic [spwm_pkg::DIV_W-1:0]   i_toggle_divide,
    output logic [TABLE_BITS-2:0]        o_rom_addr,
    output spwm_pkg::t_stage             o_stage
);

    localparam int QBITS = TABLE_BITS - 2;

    logic [PHASE_BITS-1:0]            r_phase;
    logic [PHASE_BITS-1:0]            n_phase;
    logic [spwm_pkg::CNT_W-1:0]       r_tick_count;
    logic [spwm_pkg::CNT_W-1:0]       n_tick_count;
    logic [spwm_pkg::CNT_W-1:0]       w_cnt_inc;
    logic                             w_led;
    logic [PHASE_BITS+spwm_pkg::STEP_W-1:0] w_step_ext;
    logic [PHASE_BITS+TABLE_BITS-1:0] w_phase_cat;
    logic [TABLE_BITS-1:0]            w_idx;
    logic [QBITS-1:0]                 w_quarter_pos;
    spwm_pkg::t_stage                 r_stage;

    assign w_step_ext  = {{PHASE_BITS{1'b0}}, i_phase_step};
    assign n_phase     = r_phase + w_step_ext[PHASE_BITS-1:0];

    // top table bits of the phase, padded with zeros when the phase is narrower
    assign w_phase_cat = {n_phase, {TABLE_BITS{1'b0}}};
    assign w_idx       = w_phase_cat[PHASE_BITS+TABLE_BITS-1 -: TABLE_BITS];
    assign w_quarter_pos = w_idx[QBITS-1:0];

    // odd quadrants run the quarter wave backwards
    always_comb begin
        if (w_idx[QBITS]) begin
            o_rom_addr = {1'b1, {QBITS{1'b0}}} - {1'b0, w_quarter_pos};
        end else begin
            o_rom_addr = {1'b0, w_quarter_pos};
        end
    end

    assign w_cnt_inc = r_tick_count + spwm_pkg::CNT_W'(1);
    assign w_led     = (w_cnt_inc == i_toggle_divide);

    always_comb begin
        if (w_led) begin
            n_tick_count = '0;
        end else begin
            n_tick_count = w_cnt_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= '0;
            r_tick_count <= '0;
            r_stage      <= '0;
        end else begin
            if (i_take) begin
                r_phase      <= n_phase;
                r_tick_count <= n_tick_count;
            end
            if (i_en) begin
                r_stage.valid <= i_take;
                r_stage.neg   <= w_idx[TABLE_BITS-1];
                r_stage.led   <= w_led;
            end
        end
    end

    assign o_stage = r_stage;

endmodule

// File: rtl/spwm_compare.sv
// gain multiply then offset add and subtract with saturation
module spwm_compare (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  spwm_pkg::t_stage             i_stage,
    input  logic [spwm_pkg::SINE_W-1:0]  i_sine,
    input  logic [spwm_pkg::GAIN_W-1:0]  i_sine_gain,
    input  logic [spwm_pkg::OFFS_W-1:0]  i_mid_offset,
    output spwm_pkg::t_stage             o_stage,
    output logic [spwm_pkg::CMP_W-1:0]   o_compare_a,
    output logic [spwm_pkg::CMP_W-1:0]   o_compare_b
);

    localparam int PROD_W = spwm_pkg::SINE_W + spwm_pkg::GAIN_W;

    logic [PROD_W-1:0]                w_prod;
    logic [spwm_pkg::AMP_W-1:0]       r_amp;
    spwm_pkg::t_stage                 r_stage2;
    spwm_pkg::t_stage                 r_stage3;
    logic [spwm_pkg::OFFS_W:0]        w_sum;
    logic [spwm_pkg::OFFS_W:0]        w_diff;
    logic [spwm_pkg::CMP_W-1:0]       w_plus;
    logic [spwm_pkg::CMP_W-1:0]       w_minus;
    logic [spwm_pkg::CMP_W-1:0]       r_compare_a;
    logic [spwm_pkg::CMP_W-1:0]       r_compare_b;

    assign w_prod = PROD_W'(i_sine) * PROD_W'(i_sine_gain);

    assign w_sum  = {1'b0, i_mid_offset} + {1'b0, r_amp};
    assign w_diff = {1'b0, i_mid_offset} - {1'b0, r_amp};
    assign w_plus  = w_sum[spwm_pkg::OFFS_W]  ? {spwm_pkg::CMP_W{1'b1}} : w_sum[spwm_pkg::CMP_W-1:0];
    assign w_minus = w_diff[spwm_pkg::OFFS_W] ? {spwm_pkg::CMP_W{1'b0}} : w_diff[spwm_pkg::CMP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage2 <= '0;
            r_stage3 <= '0;
        end else if (i_en) begin
            r_stage2 <= i_stage;
            r_stage3 <= r_stage2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_amp <= w_prod[PROD_W-1 -: spwm_pkg::AMP_W];
            // negative half of the wave swaps the two compare values
            if (r_stage2.neg) begin
                r_compare_a <= w_minus;
                r_compare_b <= w_plus;
            end else begin
                r_compare_a <= w_plus;
                r_compare_b <= w_minus;
            end
        end
    end

    assign o_stage     = r_stage3;
    assign o_compare_a = r_compare_a;
    assign o_compare_b = r_compare_b;

endmodule

// File: rtl/sine_pwm_compare_generator_unit.sv
// top level of the sine pwm compare generator
//
// usage:
//   slave stream: one request per pwm period tick, tdata[0] is the tick flag.
//   a request with the flag low is taken and changes nothing.
//   master stream: one request per tick with tdata[15:0] compare_a,
//   tdata[31:16] compare_b and tdata[32] led_toggle.
//   config port: write enable, register index and data; written on the clock edge while write enable is high.
//   registers: 0 phase step, 1 sine gain, 2 mid offset, 3 toggle divide.
// timing:
//   three stage pipeline (phase and rom read, gain multiply, offset add and
//   saturation). one tick is taken every cycle while the output moves.
// reset:
//   phase and tick counter clear, registers return to their defaults and
//   the pipeline empties.
// stall:
//   while the output holds a result that is not taken the whole pipeline
//   freezes and o_s_tready is low.
module sine_pwm_compare_generator_unit #(
    parameter int PHASE_BITS = spwm_pkg::PHASE_BITS_DEF,
    parameter int TABLE_BITS = spwm_pkg::TABLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [spwm_pkg::S_DATA_W-1:0]     i_s_tdata,   // tick
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [spwm_pkg::M_DATA_W-1:0]     o_m_tdata,   // compare_a, compare_b, led_toggle
    input  logic                              i_cfg_we,
    input  logic [spwm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [spwm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic [spwm_pkg::STEP_W-1:0] r_phase_step;
    logic [spwm_pkg::GAIN_W-1:0] r_sine_gain;
    logic [spwm_pkg::OFFS_W-1:0] r_mid_offset;
    logic [spwm_pkg::DIV_W-1:0]  r_toggle_divide;

    logic                        w_en;
    logic                        w_take;
    logic [TABLE_BITS-2:0]       w_rom_addr;
    logic [spwm_pkg::SINE_W-1:0] w_sine;
    spwm_pkg::t_stage            w_stage1;
    spwm_pkg::t_stage            w_stage3;
    logic [spwm_pkg::CMP_W-1:0]  w_compare_a;
    logic [spwm_pkg::CMP_W-1:0]  w_compare_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step    <= spwm_pkg::PHASE_STEP_RST;
            r_sine_gain     <= spwm_pkg::SINE_GAIN_RST;
            r_mid_offset    <= spwm_pkg::MID_OFFSET_RST;
            r_toggle_divide <= spwm_pkg::TOGGLE_DIVIDE_RST;
        end else if (i_cfg_we) begin
            case (spwm_pkg::t_cfg_idx'(i_cfg_idx))
                spwm_pkg::CFG_PHASE_STEP:    r_phase_step    <= i_cfg_data;
                spwm_pkg::CFG_SINE_GAIN:     r_sine_gain     <= i_cfg_data[spwm_pkg::GAIN_W-1:0];
                spwm_pkg::CFG_MID_OFFSET:    r_mid_offset    <= i_cfg_data;
                spwm_pkg::CFG_TOGGLE_DIVIDE: r_toggle_divide <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline moves whenever the output register is empty or being emptied
    assign w_en       = !w_stage3.valid || i_m_tready;
    assign o_s_tready = w_en;
    assign w_take     = i_s_tvalid && w_en && i_s_tdata[0];

    spwm_phase_gen #(
        .PHASE_BITS (PHASE_BITS),
        .TABLE_BITS (TABLE_BITS)
    ) u_phase_gen (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_en),
        .i_take          (w_take),
        .i_phase_step    (r_phase_step),
        .i_toggle_divide (r_toggle_divide),
        .o_rom_addr      (w_rom_addr),
        .o_stage         (w_stage1)
    );

    spwm_sine_rom #(
        .QBITS (TABLE_BITS - 2)
    ) u_sine_rom (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_addr (w_rom_addr),
        .o_data (w_sine)
    );

    spwm_compare u_compare (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_stage      (w_stage1),
        .i_sine       (w_sine),
        .i_sine_gain  (r_sine_gain),
        .i_mid_offset (r_mid_offset),
        .o_stage      (w_stage3),
        .o_compare_a  (w_compare_a),
        .o_compare_b  (w_compare_b)
    );

    assign o_m_tvalid = w_stage3.valid;
    assign o_m_tdata  = {7'd0, w_stage3.led, w_compare_b, w_compare_a};

    // a held result must stop new requests
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("request taken while output stalled");

    // without saturation the two compares sit symmetric about the offset
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[15:0] != 16'hFFFF && o_m_tdata[15:0] != 16'h0000
            && o_m_tdata[31:16] != 16'hFFFF && o_m_tdata[31:16] != 16'h0000)
        |-> ({1'b0, o_m_tdata[15:0]} + {1'b0, o_m_tdata[31:16]}) == {r_mid_offset, 1'b0})
        else $error("compare pair not symmetric about offset");

    // reset empties the pipeline
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result present after reset");

endmodule

// File: tb/sv/sine_pwm_compare_generator_unit_tb.sv
// testbench for the sine pwm compare generator: predicts compare values per tick and checks them
`timescale 1ns / 1ps

module sine_pwm_compare_generator_unit_tb;
    import spwm_pkg::*;

    localparam int PHASE_W      = PHASE_BITS_DEF;
    localparam int LUT_BITS     = TABLE_BITS_DEF;
    localparam int LUT_SIZE     = 1 << LUT_BITS;
    localparam int QUARTER_BITS = LUT_BITS - 2;
    localparam int IDX_SHIFT    = PHASE_W - LUT_BITS;
    localparam longint unsigned HALF_PI_Q28 = 64'd421657428;
    localparam longint unsigned ONE_Q28     = 64'd268435456;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 300000;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic [CMP_W-1:0] cmp_a;
        logic [CMP_W-1:0] cmp_b;
        logic             led;
    } t_compare;

    class pwm_compare_model;
        int                sine_lut [LUT_SIZE];
        logic [STEP_W-1:0] step_reg;
        logic [GAIN_W-1:0] gain_reg;
        logic [OFFS_W-1:0] offs_reg;
        logic [DIV_W-1:0]  div_reg;
        logic [PHASE_W-1:0] phase;
        logic [CNT_W-1:0]  tick_cnt;
        t_compare          expected_q[$];
        int                mismatches;

        function new();
            int quad;
            int r;
            int q;
            int v;
            for (int i = 0; i < LUT_SIZE; i++) begin
                quad = (i >> QUARTER_BITS) & 3;
                r    = i & ((1 << QUARTER_BITS) - 1);
                q    = (quad & 1) ? ((1 << QUARTER_BITS) - r) : r;
                v    = quarter_wave(q);
                sine_lut[i] = (quad & 2) ? -v : v;
            end
            step_reg   = PHASE_STEP_RST;
            gain_reg   = SINE_GAIN_RST;
            offs_reg   = MID_OFFSET_RST;
            div_reg    = TOGGLE_DIVIDE_RST;
            phase      = '0;
            tick_cnt   = '0;
            mismatches = 0;
        endfunction

        // rounded sine of q quarter-table steps, taylor series in q28
        function int quarter_wave(int unsigned q);
            longint unsigned x;
            longint unsigned term;
            longint unsigned total;
            longint unsigned r;
            x     = (longint'(q) * HALF_PI_Q28) >> QUARTER_BITS;
            term  = x;
            total = x;
            for (int k = 1; k <= 6; k++) begin
                term = (term * x) >> 28;
                term = (term * x) >> 28;
                term = term / longint'((2 * k) * (2 * k + 1));
                if (k % 2) begin
                    total -= term;
                end else begin
                    total += term;
                end
            end
            r = (total * 64'd32768 + (ONE_Q28 >> 1)) >> 28;
            if (r > 64'd32768) begin
                r = 64'd32768;
            end
            return int'(r);
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PHASE_STEP:    step_reg = data[STEP_W-1:0];
                CFG_SINE_GAIN:     gain_reg = data[GAIN_W-1:0];
                CFG_MID_OFFSET:    offs_reg = data[OFFS_W-1:0];
                CFG_TOGGLE_DIVIDE: div_reg  = data[DIV_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [CMP_W-1:0] clamp16(int v);
            if (v < 0) begin
                return '0;
            end
            if (v > 65535) begin
                return '1;
            end
            return v[CMP_W-1:0];
        endfunction

        // an accepted request; a low tick changes nothing and yields no result
        function void note_tick(bit tick);
            int       entry;
            int       mag;
            int       amp;
            t_compare res;
            if (!tick) begin
                return;
            end
            phase = phase + PHASE_W'(step_reg);
            entry = sine_lut[int'(phase >> IDX_SHIFT) & (LUT_SIZE - 1)];
            mag   = (entry < 0) ? -entry : entry;
            amp   = int'((longint'(mag) * longint'(gain_reg)) >> 15);
            if (entry < 0) begin
                amp = -amp;
            end
            tick_cnt = tick_cnt + CNT_W'(1);
            res.led  = 1'b0;
            if (tick_cnt == div_reg) begin
                tick_cnt = '0;
                res.led  = 1'b1;
            end
            res.cmp_a = clamp16(int'(offs_reg) + amp);
            res.cmp_b = clamp16(int'(offs_reg) - amp);
            expected_q.push_back(res);
        endfunction

        function void flag(string what, int want, int got);
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        endfunction

        function void check_compare(logic [M_DATA_W-1:0] data);
            t_compare want;
            t_compare got;
            got.cmp_a = data[15:0];
            got.cmp_b = data[31:16];
            got.led   = data[32];
            if (expected_q.size() == 0) begin
                flag("unexpected result, compare_a", -1, got.cmp_a);
                return;
            end
            want = expected_q.pop_front();
            if (got.cmp_a !== want.cmp_a) flag("compare_a", want.cmp_a, got.cmp_a);
            if (got.cmp_b !== want.cmp_b) flag("compare_b", want.cmp_b, got.cmp_b);
            if (got.led !== want.led) flag("led_toggle", want.led, got.led);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_we   = 1'b0;
    t_cfg_idx              cfg_idx  = CFG_PHASE_STEP;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pwm_compare_model model;
    int send_pct    = 0;
    int recv_pct    = 0;
    int hold_asked  = 0;
    int hold_taken  = 0;
    int hold_left   = 0;
    int cycle_count = 0;

    sine_pwm_compare_generator_unit u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // receiver: random stalls plus a long hold-off when one is asked for
    always @(negedge clk) begin
        if (hold_asked != hold_taken) begin
            hold_taken = hold_asked;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            model.check_compare(m_tdata);
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after the request is taken
    task automatic send_tick(input bit tick);
        while (send_pct > 0 && $urandom_range(99) < send_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-1){1'b0}}, tick};
        @(posedge clk);
        while (!s_tready) begin
            @(posedge clk);
        end
        model.note_tick(tick);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (model.pending() != 0) begin
            @(negedge clk);
        end
        // a low tick may still be in the pipe
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        model.write_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic run_phase(input logic [15:0] step, input logic [15:0] gain,
                             input logic [15:0] offs, input logic [15:0] div,
                             input int ticks, input bit hold, input t_idle_mode mode);
        int sent;
        bit tick;
        sent = 0;
        drain();
        write_reg(CFG_PHASE_STEP, step);
        write_reg(CFG_SINE_GAIN, gain);
        write_reg(CFG_MID_OFFSET, offs);
        write_reg(CFG_TOGGLE_DIVIDE, div);
        cfg_we <= 1'b0;
        case (mode)
            IDLE_SEND: begin send_pct = 48; recv_pct = 0;  end
            IDLE_RECV: begin send_pct = 0;  recv_pct = 48; end
            IDLE_BOTH: begin send_pct = 25; recv_pct = 25; end
            default:   begin send_pct = 0;  recv_pct = 0;  end
        endcase
        if (hold) begin
            hold_asked++;
        end
        while (sent < ticks) begin
            tick = ($urandom_range(9) != 0);
            send_tick(tick);
            if (tick) begin
                sent++;
                // sender waits for the pipe to empty once per phase
                if (sent == ticks / 2) begin
                    drain();
                end
            end
        end
    endtask

    initial begin
        logic [15:0] step_v;
        logic [15:0] gain_v;
        logic [15:0] offs_v;
        logic [15:0] div_v;
        model = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults, with low ticks in between
        send_tick(1'b0);
        repeat (5) send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);

        // extremes: full step, masked gain, saturation high and low, divide 0 and 1
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 6, 1'b0, IDLE_NONE);
        run_phase(16'h0000, 16'h7FFF, 16'h0000, 16'd2, 5, 1'b0, IDLE_BOTH);
        run_phase(16'h4000, 16'h0000, 16'h8000, 16'd0, 5, 1'b0, IDLE_RECV);
        run_phase(16'h4000, 16'h7FFF, 16'h8000, 16'd3, 5, 1'b0, IDLE_SEND);

        for (int p = 0; p < 8; p++) begin
            step_v = (p % 3 == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000));
            gain_v = 16'($urandom);
            offs_v = 16'($urandom);
            div_v  = (p == 6) ? 16'($urandom) : 16'($urandom_range(1, 40));
            run_phase(step_v, gain_v, offs_v, div_v, 250, (p == 1 || p == 5),
                      t_idle_mode'(p % 4));
        end

        drain();
        if (model.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
